@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int PrioBits   = 16;
  localparam int PayBits    = 32;
  localparam int CountBits  = 5;
  localparam int OpBits     = 2;
  localparam int StatusBits = 2;

  localparam logic [OpBits-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpBits-1:0] OP_POP   = 2'd1;
  localparam logic [OpBits-1:0] OP_CLEAR = 2'd2;

  localparam logic [StatusBits-1:0] STATUS_OK         = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [OpBits-1:0]   opcode;
    logic [PrioBits-1:0] priority_req;
    logic [PayBits-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic                  head_valid;
    logic [PrioBits-1:0]   head_priority;
    logic [PayBits-1:0]    head_payload;
    logic [PayBits-1:0]    popped_payload;
    logic [CountBits-1:0]  entry_count;
    logic [StatusBits-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

@@ sv/spq_req_if.sv @@
// Request channel: valid/ready handshake carrying one queue operation.
// Depends on spq_pkg.
interface spq_req_if;
  logic          valid;
  logic          ready;
  spq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/spq_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one operation result.
// Depends on spq_pkg.
interface spq_rsp_if;
  logic          valid;
  logic          ready;
  spq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue, smallest priority first: top level.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_datapath.
//
//   channel  dir  payload                                         transfer when
//   req      in   opcode, priority_req, payload                   req.valid & req.ready
//   rsp      out  head_valid, head_priority, head_payload,        rsp.valid & rsp.ready
//                 popped_payload, entry_count, status
//
// One operation a cycle unless a held result is stalled: the slot compare and shift
// run in the request transfer's cycle; the output register takes the result next cycle.
// Reset clears the occupancy and the output valid; slot contents need no reset.
// A stalled result holds; req.ready stays high while the result is taken that cycle.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QueueDepth
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule

@@ sv/spq_ctrl.sv @@
// Handshake controller: tracks the result register and issues the execute command.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);

  localparam logic STATE_EMPTY = 1'b0;
  localparam logic STATE_HOLD  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready  = (state == STATE_EMPTY) || out_ready;
  assign out_valid = (state == STATE_HOLD);
  assign cmd.exec  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      STATE_EMPTY: begin
        if (cmd.exec) state_next = STATE_HOLD;
      end
      STATE_HOLD: begin
        if (cmd.exec) state_next = STATE_HOLD;
        else if (out_ready) state_next = STATE_EMPTY;
      end
      default: state_next = STATE_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/spq_datapath.sv @@
// Shift-register queue slots, insertion compare, occupancy and result register.
// Depends on spq_pkg; driven by spq_ctrl through spq_pkg::cmd_t.
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  spq_pkg::cmd_t cmd,
  input  spq_pkg::req_t req_data,
  output spq_pkg::rsp_t rsp_data
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [spq_pkg::PrioBits-1:0] slot_priority [QUEUE_DEPTH];
  logic [spq_pkg::PayBits-1:0]  slot_payload  [QUEUE_DEPTH];
  logic [spq_pkg::PrioBits-1:0] prio_next     [QUEUE_DEPTH];
  logic [spq_pkg::PayBits-1:0]  pay_next      [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       after;
  logic [CntW-1:0]              occupancy;
  logic [CntW-1:0]              occupancy_next;
  logic                         full;
  logic                         empty;
  logic                         front;
  logic                         do_push;
  logic                         do_pop;
  spq_pkg::rsp_t                rsp_next;

  assign full    = (occupancy == CntW'(QUEUE_DEPTH));
  assign empty   = (occupancy == '0);
  assign front   = empty || (req_data.priority_req < slot_priority[0]);
  assign do_push = (req_data.opcode == spq_pkg::OP_PUSH) && !full;
  assign do_pop  = (req_data.opcode == spq_pkg::OP_POP) && !empty;

  // slots at or behind the insertion point
  always_comb begin
    after[0] = front;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      after[i] = front || (CntW'(i) >= occupancy)
                 || (slot_priority[i] >= req_data.priority_req);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    always_comb begin
      prio_next[g] = slot_priority[g];
      pay_next[g]  = slot_payload[g];
      if (do_push) begin
        if (g == 0) begin
          if (after[0]) begin
            prio_next[g] = req_data.priority_req;
            pay_next[g]  = req_data.payload;
          end
        end else begin
          if (after[g - (g > 0 ? 1 : 0)]) begin
            prio_next[g] = slot_priority[g - (g > 0 ? 1 : 0)];
            pay_next[g]  = slot_payload[g - (g > 0 ? 1 : 0)];
          end else if (after[g]) begin
            prio_next[g] = req_data.priority_req;
            pay_next[g]  = req_data.payload;
          end
        end
      end else if (do_pop && (g < QUEUE_DEPTH - 1)) begin
        prio_next[g] = slot_priority[g + (g < QUEUE_DEPTH - 1 ? 1 : 0)];
        pay_next[g]  = slot_payload[g + (g < QUEUE_DEPTH - 1 ? 1 : 0)];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        slot_priority[g] <= prio_next[g];
        slot_payload[g]  <= pay_next[g];
      end
    end
  end

  always_comb begin
    occupancy_next = occupancy;
    if (do_push) occupancy_next = occupancy + CntW'(1);
    else if (do_pop) occupancy_next = occupancy - CntW'(1);
    else if (req_data.opcode == spq_pkg::OP_CLEAR) occupancy_next = '0;

    rsp_next.head_valid     = (occupancy_next != '0);
    rsp_next.head_priority  = rsp_next.head_valid ? prio_next[0] : '0;
    rsp_next.head_payload   = rsp_next.head_valid ? pay_next[0] : '0;
    rsp_next.popped_payload = do_pop ? slot_payload[0] : '0;
    rsp_next.entry_count    = spq_pkg::CountBits'(occupancy_next);
    rsp_next.status         = spq_pkg::STATUS_OK;
    if ((req_data.opcode == spq_pkg::OP_PUSH) && full) begin
      rsp_next.status = spq_pkg::STATUS_PUSH_FULL;
    end else if ((req_data.opcode == spq_pkg::OP_POP) && empty) begin
      rsp_next.status = spq_pkg::STATUS_POP_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.exec) begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_data <= rsp_next;
    end
  end

endmodule
